// ===== hdl/point_to_angle_octant_atan_defines.svh =====
// Assertion macros for the top-level file, which checks its own logic.
`ifndef POINT_TO_ANGLE_OCTANT_ATAN_DEFINES_SVH
`define POINT_TO_ANGLE_OCTANT_ATAN_DEFINES_SVH
`ifndef SYNTHESIS
`define PTAOA_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`define PTAOA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define PTAOA_ASSERT_NEVER(label, clk, rst, cond)
`define PTAOA_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/ptaoa_pkg.sv =====
package ptaoa_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW = 2;

   localparam logic [15:0] BASE_ZERO = 16'd0;
   localparam logic [15:0] BASE_Q1_SUB = 16'd16383;
   localparam logic [15:0] BASE_Q1_ADD = 16'd16384;
   localparam logic [15:0] BASE_Q2_SUB = 16'd32767;
   localparam logic [15:0] BASE_Q2_ADD = 16'd32768;
   localparam logic [15:0] BASE_Q3_SUB = 16'd49151;
   localparam logic [15:0] BASE_Q3_ADD = 16'd49152;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic [15:0] base;
      logic        sub;
      logic        borrow;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic [QUEUE_AW:0] count;
   } queue_status_type;

endpackage

// ===== hdl/point_to_angle_octant_atan.sv =====
// Angle from one 16.16 fixed-point point to another as a 16-bit binary angle.
// Input channel: req_valid/req_ready with req_from_x, req_from_y, req_to_x and
// req_to_y. Result channel: rsp_valid/rsp_ready with rsp_angle, where 65536 is
// a full circle. Every input transfer gives exactly one result, in order.
// A front stage forms the difference vector and picks the octant, a four-entry
// queue holds classified items, and the back end runs a restoring divider with
// one quotient bit per stage, then the arctangent ROM and the final offset.
// The divider depth grows with SLOPE_STEPS. Throughput is one item per cycle
// while the receiver keeps taking results.
// When the receiver stalls, the back end holds while the queue and the front
// stage keep taking up to five more items before req_ready drops.
// Synchronous reset empties the queue and clears all valid flags; there is no
// configuration and no state carried between items.
`include "point_to_angle_octant_atan_defines.svh"

module point_to_angle_octant_atan #(
   parameter int unsigned SLOPE_STEPS = 2048
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_from_x,
   input  logic [31:0]   req_from_y,
   input  logic [31:0]   req_to_x,
   input  logic [31:0]   req_to_y,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_angle
);

   logic                                push;
   logic                                pop;
   ptaoa_pkg::item_type                 front_item;
   ptaoa_pkg::item_type                 head_item;
   ptaoa_pkg::queue_status_type         qstat;

   ptaoa_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_from_x(req_from_x),
      .req_from_y(req_from_y),
      .req_to_x(req_to_x),
      .req_to_y(req_to_y),
      .push(push),
      .item(front_item),
      .queue_full(qstat.full)
   );

   ptaoa_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(front_item),
      .pop(pop),
      .head_item(head_item),
      .status(qstat)
   );

   ptaoa_back #(
      .SLOPE_STEPS(SLOPE_STEPS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(!qstat.empty),
      .head_item(head_item),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_angle(rsp_angle)
   );

   `PTAOA_ASSERT_NEVER(a_push_full, clock, reset, push && qstat.full)
   `PTAOA_ASSERT_NEVER(a_pop_empty, clock, reset, pop && qstat.empty)
   `PTAOA_ASSERT_NEVER(a_count_range, clock, reset, qstat.count > 3'd4)
   `PTAOA_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push, qstat.count == $past(qstat.count) - 3'd1)

endmodule

// ===== hdl/ptaoa_front.sv =====
module ptaoa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_from_x,
   input  logic [31:0]           req_from_y,
   input  logic [31:0]           req_to_x,
   input  logic [31:0]           req_to_y,
   output logic                  push,
   output ptaoa_pkg::item_type   item,
   input  logic                  queue_full
);

   logic                 valid_ff;
   ptaoa_pkg::item_type  item_ff;
   ptaoa_pkg::item_type  item_in;
   logic [31:0]          dx;
   logic [31:0]          dy;
   logic [31:0]          nx;
   logic [31:0]          ny;

   assign push = valid_ff && !queue_full;
   assign req_ready = !valid_ff || !queue_full;
   assign item = item_ff;

   always_comb begin
      dx = req_to_x - req_from_x;
      dy = req_to_y - req_from_y;
      nx = 32'd0 - dx;
      ny = 32'd0 - dy;
      item_in = '0;
      if (dx == 32'd0 && dy == 32'd0) begin
         // A zero numerator over the largest denominator gives slope zero and angle zero.
         item_in.den = '1;
         item_in.base = ptaoa_pkg::BASE_ZERO;
      end else if (!dx[31]) begin
         if (!dy[31]) begin
            if ($signed(dx) > $signed(dy)) begin
               item_in.num = dy;
               item_in.den = dx;
               item_in.base = ptaoa_pkg::BASE_ZERO;
            end else begin
               item_in.num = dx;
               item_in.den = dy;
               item_in.base = ptaoa_pkg::BASE_Q1_SUB;
               item_in.sub = 1'b1;
            end
         end else begin
            if ($signed(dx) > $signed(ny)) begin
               item_in.num = ny;
               item_in.den = dx;
               item_in.base = ptaoa_pkg::BASE_ZERO;
               item_in.sub = 1'b1;
               item_in.borrow = 1'b1;
            end else begin
               item_in.num = dx;
               item_in.den = ny;
               item_in.base = ptaoa_pkg::BASE_Q3_ADD;
            end
         end
      end else begin
         if (!dy[31]) begin
            if ($signed(nx) > $signed(dy)) begin
               item_in.num = dy;
               item_in.den = nx;
               item_in.base = ptaoa_pkg::BASE_Q2_SUB;
               item_in.sub = 1'b1;
            end else begin
               item_in.num = nx;
               item_in.den = dy;
               item_in.base = ptaoa_pkg::BASE_Q1_ADD;
            end
         end else begin
            if ($signed(nx) > $signed(ny)) begin
               item_in.num = ny;
               item_in.den = nx;
               item_in.base = ptaoa_pkg::BASE_Q2_ADD;
            end else begin
               item_in.num = nx;
               item_in.den = ny;
               item_in.base = ptaoa_pkg::BASE_Q3_SUB;
               item_in.sub = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hdl/ptaoa_queue.sv =====
module ptaoa_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ptaoa_pkg::item_type           push_item,
   input  logic                          pop,
   output ptaoa_pkg::item_type           head_item,
   output ptaoa_pkg::queue_status_type   status
);

   ptaoa_pkg::item_type                  store_ff [ptaoa_pkg::QUEUE_DEPTH];
   logic [ptaoa_pkg::QUEUE_AW-1:0]       wr_ptr_ff;
   logic [ptaoa_pkg::QUEUE_AW-1:0]       rd_ptr_ff;
   logic [ptaoa_pkg::QUEUE_AW:0]         count_ff;

   assign head_item = store_ff[rd_ptr_ff];
   assign status.full = (count_ff == (ptaoa_pkg::QUEUE_AW + 1)'(ptaoa_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/ptaoa_rom.sv =====
module ptaoa_rom #(
   parameter int unsigned SLOPE_STEPS = 2048,
   parameter int unsigned AW = 12
) (
   input  logic            clock,
   input  logic            enable,
   input  logic [AW-1:0]   addr,
   output logic [13:0]     data
);

   typedef logic [13:0] rom_array_type [0:SLOPE_STEPS];

   localparam real PI_VAL = 3.14159265358979323846;
   localparam real ANGLE_SCALE = 32768.0 / PI_VAL;
   localparam real STEP_SCALE = 1.0 / real'(SLOPE_STEPS);

   function automatic rom_array_type build_rom();
      rom_array_type rom;
      real           v;
      for (int s = 0; s <= int'(SLOPE_STEPS); s++) begin
         v = $atan(real'(s) * STEP_SCALE) * ANGLE_SCALE;
         rom[s] = 14'($rtoi(v));
      end
      rom[0] = 14'd0;
      rom[SLOPE_STEPS] = 14'd8192;
      return rom;
   endfunction

   localparam rom_array_type ROM = build_rom();

   always_ff @(posedge clock) begin
      if (enable) begin
         data <= ROM[addr];
      end
   end

endmodule

// ===== hdl/ptaoa_back.sv =====
module ptaoa_back #(
   parameter int unsigned SLOPE_STEPS = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ptaoa_pkg::item_type   head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_angle
);

   localparam int unsigned QB = $clog2(SLOPE_STEPS + 1);
   localparam int unsigned RW = 24 + QB + 1;
   localparam logic [QB-1:0] STEPS = QB'(SLOPE_STEPS);

   logic              en;
   logic              valid_ff [0:QB];
   logic [RW-1:0]     rem_ff [0:QB];
   logic [23:0]       div_ff [0:QB];
   logic [QB-1:0]     quo_ff [0:QB];
   logic              sat_ff [0:QB];
   logic [15:0]       base_ff [0:QB];
   logic              sub_ff [0:QB];
   logic              borrow_ff [0:QB];

   logic              rv_ff;
   logic [QB-1:0]     rslope_ff;
   logic [15:0]       rbase_ff;
   logic              rsub_ff;
   logic              rborrow_ff;
   logic [13:0]       rom_data;
   logic [QB-1:0]     slope_fin;

   logic              rsp_valid_ff;
   logic [15:0]       rsp_angle_ff;
   logic [15:0]       angle_in;

   logic [31:0]       num_sh;
   logic [23:0]       div0;

   assign en = !rsp_valid_ff || rsp_ready;
   assign pop = en && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = rsp_angle_ff;
   assign num_sh = {head_item.num[28:0], 3'b000};
   assign div0 = head_item.den[31:8];

   always_comb begin
      if (sat_ff[QB] || quo_ff[QB] > STEPS) begin
         slope_fin = STEPS;
      end else begin
         slope_fin = quo_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= int'(QB); k++) begin
            valid_ff[k] <= 1'b0;
         end
         rv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= head_valid;
         for (int k = 1; k <= int'(QB); k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rv_ff <= valid_ff[QB];
         rsp_valid_ff <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [RW-1:0] shifted;
      if (en) begin
         rem_ff[0] <= RW'(num_sh);
         div_ff[0] <= div0;
         quo_ff[0] <= '0;
         sat_ff[0] <= (head_item.den < 32'd512) ||
                      (RW'(num_sh) >= (RW'(div0) << QB));
         base_ff[0] <= head_item.base;
         sub_ff[0] <= head_item.sub;
         borrow_ff[0] <= head_item.borrow;
         for (int k = 1; k <= int'(QB); k++) begin
            shifted = RW'(div_ff[k-1]) << (int'(QB) - k);
            if (!sat_ff[k-1] && rem_ff[k-1] >= shifted) begin
               rem_ff[k] <= rem_ff[k-1] - shifted;
               quo_ff[k] <= quo_ff[k-1] | (QB'(1) << (int'(QB) - k));
            end else begin
               rem_ff[k] <= rem_ff[k-1];
               quo_ff[k] <= quo_ff[k-1];
            end
            div_ff[k] <= div_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            base_ff[k] <= base_ff[k-1];
            sub_ff[k] <= sub_ff[k-1];
            borrow_ff[k] <= borrow_ff[k-1];
         end
         rslope_ff <= slope_fin;
         rbase_ff <= base_ff[QB];
         rsub_ff <= sub_ff[QB];
         rborrow_ff <= borrow_ff[QB];
         rsp_angle_ff <= angle_in;
      end
   end

   ptaoa_rom #(
      .SLOPE_STEPS(SLOPE_STEPS),
      .AW(QB)
   ) u_rom (
      .clock(clock),
      .enable(en),
      .addr(slope_fin),
      .data(rom_data)
   );

   always_comb begin
      if (rsub_ff) begin
         angle_in = rbase_ff - 16'(rom_data);
      end else begin
         angle_in = rbase_ff + 16'(rom_data);
      end
      if (rborrow_ff && rslope_ff != '0 && rslope_ff != STEPS) begin
         angle_in = angle_in - 16'd1;
      end
   end

endmodule

// ===== bench/point_to_angle_octant_atan_tb.sv =====
`timescale 1ns / 100ps

module point_to_angle_octant_atan_tb;

   localparam int unsigned STEPS = 2048;
   localparam int unsigned LONG_HOLD = 300;

   typedef struct packed {
      logic [31:0] from_x;
      logic [31:0] from_y;
      logic [31:0] to_x;
      logic [31:0] to_y;
   } point_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_from_x = '0;
   logic [31:0] req_from_y = '0;
   logic [31:0] req_to_x = '0;
   logic [31:0] req_to_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_angle;

   point_pair_type pending_pairs[$];
   logic [15:0] expected_angles[$];
   logic [15:0] atan_rom[0:STEPS];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic sender_hold = 1'b0;
   logic start_hold = 1'b0;
   int unsigned hold_left = 0;
   int unsigned errors = 0;
   int unsigned angles_checked = 0;

   point_to_angle_octant_atan #(.SLOPE_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_from_x(req_from_x), .req_from_y(req_from_y),
      .req_to_x(req_to_x), .req_to_y(req_to_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_angle(rsp_angle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned q_mul(longint unsigned a, longint unsigned b);
      return ((a * (b >> 20)) >> 20) + ((a * (b & 64'hFFFFF)) >> 40);
   endfunction

   function automatic longint unsigned atan_series(longint unsigned y);
      longint unsigned y2, p, pos, neg, term;
      y2 = q_mul(y, y);
      p = y;
      pos = 0;
      neg = 0;
      for (int k = 0; k < 40; k++) begin
         term = p / longint'(2 * k + 1);
         if (k % 2 == 0) pos += term;
         else neg += term;
         p = q_mul(p, y2);
      end
      return (pos >= neg) ? pos - neg : 0;
   endfunction

   task automatic build_atan_rom();
      longint unsigned one, quarter, a, r, n, s;
      one = 64'd1 << 40;
      n = STEPS;
      quarter = 4 * atan_series(one / 5) - atan_series(one / 239);
      for (int i = 0; i <= STEPS; i++) begin
         s = i;
         if (s == 0) a = 0;
         else if (2 * s <= n) a = atan_series((s << 40) / n);
         else begin
            r = atan_series(((n - s) << 40) / (n + s));
            a = (quarter >= r) ? quarter - r : 0;
         end
         if (a > quarter) a = quarter;
         atan_rom[i] = 16'((a * 8192) / quarter);
      end
   endtask

   function automatic logic [31:0] slope_index(logic [31:0] num, logic [31:0] den);
      logic [31:0] shifted, q;
      if (den < 32'd512) return STEPS;
      shifted = num << 3;
      q = shifted / (den >> 8);
      return (q <= STEPS) ? q : STEPS;
   endfunction

   function automatic logic [15:0] predict_angle(point_pair_type p);
      logic [31:0] dx, dy, s;
      logic [15:0] r;
      dx = p.to_x - p.from_x;
      dy = p.to_y - p.from_y;
      if (dx == 0 && dy == 0) r = 16'd0;
      else if (!dx[31]) begin
         if (!dy[31]) begin
            if ($signed(dx) > $signed(dy)) r = atan_rom[slope_index(dy, dx)];
            else r = 16'd16383 - atan_rom[slope_index(dx, dy)];
         end else begin
            dy = -dy;
            if ($signed(dx) > $signed(dy)) begin
               s = slope_index(dy, dx);
               r = 16'd0 - atan_rom[s] - ((s != 0 && s != STEPS) ? 16'd1 : 16'd0);
            end else r = 16'd49152 + atan_rom[slope_index(dx, dy)];
         end
      end else begin
         dx = -dx;
         if (!dy[31]) begin
            if ($signed(dx) > $signed(dy)) r = 16'd32767 - atan_rom[slope_index(dy, dx)];
            else r = 16'd16384 + atan_rom[slope_index(dx, dy)];
         end else begin
            dy = -dy;
            if ($signed(dx) > $signed(dy)) r = 16'd32768 + atan_rom[slope_index(dy, dx)];
            else r = 16'd49151 - atan_rom[slope_index(dx, dy)];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            expected_angles.push_back(predict_angle({req_from_x, req_from_y,
                                                     req_to_x, req_to_y}));
         if (pending_pairs.size() != 0 && !sender_hold &&
             $urandom_range(99) >= send_idle_pct) begin
            point_pair_type p;
            p = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_from_x <= p.from_x;
            req_from_y <= p.from_y;
            req_to_x <= p.to_x;
            req_to_y <= p.to_y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (start_hold) hold_left <= LONG_HOLD;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_angles.size() == 0) begin
               $display("%0t: unexpected transfer, angle %0d", $time, rsp_angle);
               errors++;
            end else begin
               logic [15:0] want;
               want = expected_angles.pop_front();
               angles_checked++;
               if (rsp_angle !== want) begin
                  $display("%0t: angle mismatch, expected %0d, actual %0d",
                           $time, want, rsp_angle);
                  errors++;
               end
            end
         end
         rsp_ready <= (hold_left == 0 && !start_hold) &&
                      ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic point_pair_type random_pair();
      point_pair_type p;
      logic [31:0] base_x, base_y, d;
      base_x = $urandom;
      base_y = $urandom;
      p = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(5))
         0: ;
         1: begin
            p.from_x = base_x;
            p.from_y = base_y;
            p.to_x = base_x + 32'($urandom_range(2000)) - 32'd1000;
            p.to_y = base_y + 32'($urandom_range(2000)) - 32'd1000;
         end
         2: begin
            d = $urandom_range(1 << 20);
            p.from_x = base_x;
            p.from_y = base_y;
            p.to_x = base_x + ($urandom_range(1) ? d : -d);
            p.to_y = base_y + ($urandom_range(1) ? d : -d) + 32'($urandom_range(2)) - 32'd1;
         end
         3: begin
            p.from_x = base_x;
            p.from_y = base_y;
            p.to_x = $urandom_range(1) ? base_x : base_x + 32'h8000_0000;
            p.to_y = base_y + (32'($urandom) >>> $urandom_range(31));
         end
         default: begin
            p.from_x = base_x;
            p.from_y = base_y;
            p.to_x = base_x + ($urandom >> $urandom_range(31)) * ($urandom_range(1) ? 1 : -1);
            p.to_y = base_y + ($urandom >> $urandom_range(31)) * ($urandom_range(1) ? 1 : -1);
         end
      endcase
      return p;
   endfunction

   task automatic add_vector(logic [31:0] dx, logic [31:0] dy);
      logic [31:0] bx, by;
      bx = $urandom;
      by = $urandom;
      pending_pairs.push_back({bx, by, bx + dx, by + dy});
   endtask

   task automatic drain();
      do @(negedge clock); while (pending_pairs.size() != 0 || req_valid);
      sender_hold = 1'b1;
      do @(negedge clock); while (expected_angles.size() != 0);
      repeat (30) @(posedge clock);
      sender_hold = 1'b0;
   endtask

   initial begin
      build_atan_rom();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_vector(0, 0);
      pending_pairs.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
      add_vector(32'h0001_0000, 0);
      add_vector(0, 32'h0001_0000);
      add_vector(-32'sd65536, 0);
      add_vector(0, -32'sd65536);
      add_vector(32'd1000, 32'd1000);
      add_vector(-32'sd1000, 32'd1000);
      add_vector(-32'sd1000, -32'sd1000);
      add_vector(32'd1000, -32'sd1000);
      add_vector(32'd300, 32'd100);
      add_vector(32'd300, -32'sd100);
      add_vector(32'h8000_0000, 0);
      add_vector(0, 32'h8000_0000);
      add_vector(32'h8000_0000, 32'h8000_0000);
      add_vector(32'h7FFF_FFFF, 32'h8000_0000);
      add_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_vector(32'h0100_0000, 32'h0000_0100);
      add_vector(32'h0100_0000, -32'sd256);
      add_vector(32'h0001_0000, -32'sd65535);
      add_vector(32'h4000_0000, 32'h3FFF_0000);
      add_vector(32'h3000_0000, -32'sh2000_0000);
      add_vector(-32'sh3000_0000, 32'h1000_0000);
      add_vector(-32'sh1000_0000, -32'sh3000_0000);
      add_vector(32'd511, 32'd7);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         for (int i = 0; i < 170; i++) pending_pairs.push_back(random_pair());
         if (phase == 0) begin
            repeat (20) @(posedge clock);
            start_hold <= 1'b1;
            @(posedge clock);
            start_hold <= 1'b0;
         end
         drain();
      end

      repeat (40) @(posedge clock);
      $display("Checked %0d angles across all octants, axis, diagonal, wrap and",
               angles_checked);
      $display("short-vector cases under four idle and stall mixes plus a long hold.");
      if (errors == 0 && expected_angles.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Run timed out with %0d results outstanding.", expected_angles.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
